// ===== hw/rtl/poly_voice_allocator_assert.svh =====
// Assertion shorthands for the voice allocator
`ifndef POLY_VOICE_ALLOCATOR_ASSERT_SVH
`define POLY_VOICE_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define PVA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PVA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/pva_pkg.sv =====
package pva_pkg;

   localparam int NOTE_W     = 7;
   localparam int VEL_W      = 7;
   localparam int SAMPLES_W  = 12;
   localparam int OP_W       = 2;
   localparam int CNT_W      = 18;
   localparam int VOICE_W    = 4;
   localparam int RULE_W     = 2;
   localparam int MASK_W     = 16;
   localparam int GAIN_W     = 7;

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 32;

   localparam logic [CNT_W-1:0] TIMEOUT_RESET = CNT_W'(48000 * 5);

   localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd0;
   localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd1;
   localparam logic [OP_W-1:0] OP_ALL_OFF  = 2'd2;
   localparam logic [OP_W-1:0] OP_TICK     = 2'd3;

   localparam logic [RULE_W-1:0] RULE_SAME     = 2'd0;
   localparam logic [RULE_W-1:0] RULE_FREE     = 2'd1;
   localparam logic [RULE_W-1:0] RULE_STEAL    = 2'd2;
   localparam logic [RULE_W-1:0] RULE_FALLBACK = 2'd3;

   typedef struct packed {
      logic [NOTE_W-1:0] note;
      logic              nv;
      logic              gate;
      logic [CNT_W-1:0]  cnt;
   } entry_type;

endpackage

// ===== hw/rtl/poly_voice_allocator.sv =====
// Channel   Dir  Handshake              Payload
// req       in   req_tvalid/req_tready  tuser op, tdata note/velocity/samples
// rsp       out  rsp_tvalid/rsp_tready  tdata voice/pick_rule/voice_mask/gain
// csr       in   csr_valid/csr_ready    csr_data ring_limit
//
// Note on, note off and non-empty tick: the voice memory is read and scanned
// one entry a cycle, then the result is registered; note on first writes the
// picked voice. All notes off and empty ticks go straight to the result.
// Reset marks every entry unwritten; no clearing pass.
// A new item is taken once the previous result sits in the output register.
module poly_voice_allocator #(
   parameter int VOICES    = 16,
   parameter int BLOCK_MAX = 512
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [pva_pkg::REQ_TDATA_W-1:0]    req_tdata,  // note, velocity, samples
   input  logic [pva_pkg::OP_W-1:0]           req_tuser,  // op
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pva_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // voice, pick_rule, voice_mask, gain
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pva_pkg::CNT_W-1:0]          csr_data    // ring_limit
);
   import pva_pkg::*;

   localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICES - 1);
   localparam logic [SAMPLES_W:0] BLK_LIM = (SAMPLES_W + 1)'(BLOCK_MAX);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_WR   = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]            state_ff;
   logic [OP_W-1:0]       op_ff;
   logic [NOTE_W-1:0]     note_ff;
   logic [VEL_W-1:0]      vel_ff;
   logic [SAMPLES_W-1:0]  n_ff;
   logic [CNT_W-1:0]      ring_limit_ff;
   logic [CNT_W-1:0]      clr_count_ff;
   logic [VOICES-1:0]     vld_ff;

   logic [IDX_W-1:0]      iss_ff;
   logic                  iss_act_ff;
   logic                  proc_vld_ff;
   logic [IDX_W-1:0]      proc_idx_ff;
   entry_type             rd_q_ff;
   logic                  rd_vld_ff;

   logic                  same_fnd_ff, free_fnd_ff, st_fnd_ff;
   logic [IDX_W-1:0]      same_idx_ff, free_idx_ff, st_idx_ff;
   logic [CNT_W-1:0]      st_cnt_ff;
   logic [MASK_W-1:0]     mask_ff;

   logic                  rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   entry_type             mem [VOICES];

   logic [OP_W-1:0]       req_op;
   logic [NOTE_W-1:0]     req_note;
   logic [VEL_W-1:0]      req_vel;
   logic [SAMPLES_W-1:0]  req_samples;
   logic [SAMPLES_W-1:0]  req_n;
   logic                  req_xfer;
   logic                  out_free;

   entry_type             eff;
   logic                  same_hit, free_hit, active;
   logic [CNT_W:0]        sum;
   logic [CNT_W-1:0]      sat;
   logic [MASK_W-1:0]     proc_bit, pick_bit;
   logic [IDX_W-1:0]      pick_idx;
   logic [RULE_W-1:0]     pick_rule;

   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   entry_type             wr_data;

   assign req_op      = req_tuser;
   assign req_note    = req_tdata[6:0];
   assign req_vel     = req_tdata[13:7];
   assign req_samples = req_tdata[25:14];
   assign req_n       = ({1'b0, req_samples} < BLK_LIM) ? req_samples
                                                        : BLK_LIM[SAMPLES_W-1:0];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      if (rd_vld_ff) begin
         eff = rd_q_ff;
      end else begin
         eff.note = '0;
         eff.nv   = 1'b0;
         eff.gate = 1'b0;
         eff.cnt  = clr_count_ff;
      end
   end

   assign same_hit = eff.gate && eff.nv && (eff.note == note_ff);
   assign free_hit = !eff.gate && (eff.cnt >= ring_limit_ff);
   assign active   = eff.gate || (eff.cnt < ring_limit_ff);
   assign sum      = {1'b0, eff.cnt} + (CNT_W + 1)'(n_ff);
   assign sat      = (sum > {1'b0, ring_limit_ff}) ? ring_limit_ff : sum[CNT_W-1:0];
   assign proc_bit = MASK_W'(1) << proc_idx_ff;

   always_comb begin
      priority if (same_fnd_ff) begin
         pick_idx  = same_idx_ff;
         pick_rule = RULE_SAME;
      end else if (free_fnd_ff) begin
         pick_idx  = free_idx_ff;
         pick_rule = RULE_FREE;
      end else if (st_fnd_ff) begin
         pick_idx  = st_idx_ff;
         pick_rule = RULE_STEAL;
      end else begin
         pick_idx  = '0;
         pick_rule = RULE_FALLBACK;
      end
   end

   assign pick_bit = MASK_W'(1) << pick_idx;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = proc_idx_ff;
      wr_data = eff;
      if (proc_vld_ff) begin
         unique case (op_ff)
            OP_NOTE_OFF: begin
               if (same_hit) begin
                  wr_en        = 1'b1;
                  wr_data.gate = 1'b0;
                  wr_data.cnt  = '0;
               end
            end
            OP_TICK: begin
               if (active && !eff.gate) begin
                  wr_en       = 1'b1;
                  wr_data.cnt = sat;
               end
            end
            OP_NOTE_ON, OP_ALL_OFF: begin
               wr_en = 1'b0;
            end
         endcase
      end
      if (state_ff == ST_WR) begin
         wr_en        = 1'b1;
         wr_addr      = pick_idx;
         wr_data.note = note_ff;
         wr_data.nv   = 1'b1;
         wr_data.gate = 1'b1;
         wr_data.cnt  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (iss_act_ff) begin
         rd_q_ff   <= mem[iss_ff];
         rd_vld_ff <= vld_ff[iss_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_limit_ff <= TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         ring_limit_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vld_ff       <= '0;
         clr_count_ff <= TIMEOUT_RESET;
         iss_act_ff   <= 1'b0;
         proc_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         proc_vld_ff <= iss_act_ff;
         proc_idx_ff <= iss_ff;
         if (iss_act_ff) begin
            iss_ff <= iss_ff + 1'b1;
            if (iss_ff == LAST_IDX) begin
               iss_act_ff <= 1'b0;
            end
         end
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         if (proc_vld_ff) begin
            if (same_hit && !same_fnd_ff) begin
               same_fnd_ff <= 1'b1;
               same_idx_ff <= proc_idx_ff;
            end
            if (free_hit && !free_fnd_ff) begin
               free_fnd_ff <= 1'b1;
               free_idx_ff <= proc_idx_ff;
            end
            if (!eff.gate && (!st_fnd_ff || eff.cnt > st_cnt_ff)) begin
               st_fnd_ff <= 1'b1;
               st_idx_ff <= proc_idx_ff;
               st_cnt_ff <= eff.cnt;
            end
            if ((op_ff == OP_NOTE_OFF && same_hit) || (op_ff == OP_TICK && active)) begin
               mask_ff <= mask_ff | proc_bit;
            end
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  note_ff     <= req_note;
                  vel_ff      <= req_vel;
                  n_ff        <= req_n;
                  mask_ff     <= '0;
                  same_fnd_ff <= 1'b0;
                  free_fnd_ff <= 1'b0;
                  st_fnd_ff   <= 1'b0;
                  iss_ff      <= '0;
                  op_ff       <= (req_op == OP_NOTE_ON && req_vel == '0) ? OP_NOTE_OFF
                                                                          : req_op;
                  if (req_op == OP_ALL_OFF) begin
                     vld_ff       <= '0;
                     clr_count_ff <= ring_limit_ff;
                     state_ff     <= ST_DONE;
                  end else if (req_op == OP_TICK && req_n == '0) begin
                     state_ff <= ST_DONE;
                  end else begin
                     iss_act_ff <= 1'b1;
                     state_ff   <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               if (proc_vld_ff && proc_idx_ff == LAST_IDX) begin
                  state_ff <= (op_ff == OP_NOTE_ON) ? ST_WR : ST_DONE;
               end
            end
            ST_WR: begin
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
                  if (op_ff == OP_NOTE_ON) begin
                     rsp_data_ff <= {3'b000, vel_ff, pick_bit, pick_rule, VOICE_W'(pick_idx)};
                  end else begin
                     rsp_data_ff <= {3'b000, GAIN_W'(0), mask_ff, RULE_SAME, VOICE_W'(0)};
                  end
               end
            end
         endcase
      end
   end

`include "poly_voice_allocator_assert.svh"

   `PVA_ASSERT_NOW(a_proc_in_scan, clock, reset, proc_vld_ff, state_ff == ST_SCAN, "scan stage active outside scan")
   `PVA_ASSERT_NEXT(a_load_result, clock, reset, (state_ff == ST_DONE) && out_free, rsp_valid_ff, "result not loaded")
   `PVA_ASSERT_NEXT(a_all_off_clear, clock, reset, req_xfer && (req_op == OP_ALL_OFF), vld_ff == '0, "entries not cleared")
   `PVA_ASSERT_NOW(a_note_on_onehot, clock, reset, rsp_valid_ff && (rsp_data_ff[28:22] != '0), $onehot0(rsp_data_ff[21:6]), "note on mask not one-hot")

endmodule
